// File: src/gld_pkg.sv
package gld_pkg;

	localparam int IQ_W     = 16;
	localparam int PER_W    = 17;
	localparam int ALPHA_W  = 16;
	localparam int CNO_W    = 32;
	localparam int RAT_W    = 16;

	localparam int WARMUP_DEF = 100;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;
	localparam logic [CNO_W-1:0]   CNO_RESET   = 32'd1000;
	localparam logic [CNO_W-1:0]   CNO_LOCK    = 32'd1000;
	localparam logic [CNO_W-1:0]   CNO_MAX     = 32'hFFFF_FFFF;
	localparam logic signed [RAT_W-1:0] RATIO_LOCK = 16'sd28377;
	localparam logic signed [RAT_W-1:0] RATIO_MAX  = 16'sh7FFF;
	localparam logic signed [RAT_W-1:0] RATIO_MIN  = 16'sh8000;
	localparam logic [19:0]        CNO_SCALE   = 20'd1000000;

endpackage

// File: src/gld_if.sv
interface gld_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [gld_pkg::IQ_W-1:0]   prompt_in_phase;
	logic signed [gld_pkg::IQ_W-1:0]   prompt_quadrature;
	logic        [gld_pkg::PER_W-1:0]  period_us;
	modport source(output valid, prompt_in_phase, prompt_quadrature, period_us, input ready);
	modport sink(input valid, prompt_in_phase, prompt_quadrature, period_us, output ready);
endinterface

interface gld_out_if;
	logic                              valid;
	logic                              ready;
	logic                              cno_lock;
	logic                              carrier_lock;
	logic        [gld_pkg::CNO_W-1:0]  cno_estimate;
	logic signed [gld_pkg::RAT_W-1:0]  carrier_ratio;
	modport source(output valid, cno_lock, carrier_lock, cno_estimate, carrier_ratio,
		input ready);
	modport sink(input valid, cno_lock, carrier_lock, cno_estimate, carrier_ratio,
		output ready);
endinterface

interface gld_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [gld_pkg::ALPHA_W-1:0]        data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// File: src/gnss_lock_detector_with_warmup.sv
// The C/N0 division is skipped when its divisor is zero, and the ratio division
// when the power is zero; in warm-up neither C/N0 nor ratio is computed.
// No beat is taken while busy; a stalled result holds the end.
// One sequencer: a 24-step square root run twice, a 20-step shift-add multiplier and a
// restoring divider (48, 32 or 15 steps) shared by filters, C/N0 and ratio.
// Reset (arst_n low, async): filters, count, period cleared; C/N0 1000, ratio 0, gain 3277.
module gnss_lock_detector_with_warmup #(
	parameter int WARMUP_DUMPS = gld_pkg::WARMUP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gld_in_if.sink     sample,
	gld_out_if.source  result,
	gld_cfg_if.sink    cfg
);

	localparam int CW = $clog2(WARMUP_DUMPS + 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SQI  = 5'd1;
	localparam logic [4:0] ST_SQQ  = 5'd2;
	localparam logic [4:0] ST_PW   = 5'd3;
	localparam logic [4:0] ST_RT   = 5'd4;
	localparam logic [4:0] ST_NZ   = 5'd5;
	localparam logic [4:0] ST_FSET = 5'd6;
	localparam logic [4:0] ST_MUL  = 5'd7;
	localparam logic [4:0] ST_DIV  = 5'd8;
	localparam logic [4:0] ST_FUPD = 5'd9;
	localparam logic [4:0] ST_CNO1 = 5'd10;
	localparam logic [4:0] ST_CNO2 = 5'd11;
	localparam logic [4:0] ST_CNO3 = 5'd12;
	localparam logic [4:0] ST_CNOF = 5'd13;
	localparam logic [4:0] ST_RAT  = 5'd14;
	localparam logic [4:0] ST_RATF = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;

	logic [4:0]         st_q, ret_q;
	logic signed [15:0] i_q, q_q;
	logic [16:0]        per_q, last_q;
	logic [31:0]        ii_q, qq_q, pcur_q, prev_q;
	logic signed [31:0] pdiff_q;
	logic [47:0]        rv_q;
	logic [25:0]        rrem_q;
	logic [23:0]        rroot_q, rc_q;
	logic [4:0]         rcnt_q;
	logic               rsel_q;
	logic [47:0]        nz_q;
	logic               warm_q, neg_q;
	logic [CW-1:0]      cnt_q;
	logic [1:0]         fidx_q;
	logic [47:0]        sig_q, noi_q, dif_q, pow_q;
	logic signed [69:0] mc_q, acc_q;
	logic [19:0]        mp_q;
	logic [4:0]         mcnt_q;
	logic [64:0]        rem_q, den_q;
	logic [67:0]        nlo_q, num_q;
	logic [47:0]        dq_q;
	logic [5:0]         dcnt_q;
	logic               ov_q;
	logic [15:0]        alpha_q;
	logic [31:0]        hcno_q;
	logic signed [15:0] hrat_q;
	logic               ovld_q;
	logic               olock_c_q, olock_r_q;
	logic [31:0]        ocno_q;
	logic signed [15:0] orat_q;

	logic [26:0]        rem2, trial, rrem_nxt;
	logic               rt_ge;
	logic [23:0]        root_nxt;
	logic signed [24:0] dr;
	logic signed [49:0] drsq;
	logic signed [48:0] x_sel, s_sel, dd, addv, snew;
	logic [47:0]        dm;
	logic [65:0]        dt;
	logic               d_ge;
	logic [62:0]        rm;

	always_comb begin
		rem2     = {rrem_q[24:0], rv_q[47:46]};
		trial    = {1'b0, rroot_q, 2'b01};
		rt_ge    = rem2 >= trial;
		rrem_nxt = rt_ge ? rem2 - trial : rem2;
		root_nxt = {rroot_q[22:0], rt_ge};
		// root of the previous power is kept in rroot_q once both roots are done
		dr       = $signed({1'b0, rc_q}) - $signed({1'b0, rroot_q});
		drsq     = 50'(dr) * 50'(dr);
		case (fidx_q)
			2'd0: begin
				x_sel = {1'b0, ({1'b0, prev_q} + {1'b0, pcur_q}), 15'b0};
				s_sel = {1'b0, sig_q};
			end
			2'd1: begin
				x_sel = {1'b0, nz_q};
				s_sel = {1'b0, noi_q};
			end
			2'd2: begin
				x_sel = {pdiff_q[31], pdiff_q, 16'b0};
				s_sel = {dif_q[47], dif_q};
			end
			default: begin
				x_sel = {1'b0, pcur_q, 16'b0};
				s_sel = {1'b0, pow_q};
			end
		endcase
		dd   = x_sel - s_sel;
		dm   = dd[48] ? ~dd[47:0] : dd[47:0];
		addv = warm_q ? (neg_q ? ~{1'b0, dq_q} : {1'b0, dq_q}) : acc_q[64:16];
		snew = s_sel + addv;
		dt   = {rem_q, nlo_q[67]};
		d_ge = dt >= {1'b0, den_q};
		rm   = dif_q[47] ? ~{dif_q, 15'b0} : {dif_q, 15'b0};
	end

	assign sample.ready         = (st_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign result.valid         = ovld_q;
	assign result.cno_lock      = olock_c_q;
	assign result.carrier_lock  = olock_r_q;
	assign result.cno_estimate  = ocno_q;
	assign result.carrier_ratio = orat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			i_q <= '0; q_q <= '0; per_q <= '0; last_q <= '0;
			ii_q <= '0; qq_q <= '0; pcur_q <= '0; prev_q <= '0; pdiff_q <= '0;
			rv_q <= '0; rrem_q <= '0; rroot_q <= '0; rc_q <= '0;
			rcnt_q <= '0; rsel_q <= 1'b0; nz_q <= '0;
			warm_q <= 1'b0; neg_q <= 1'b0; cnt_q <= '0; fidx_q <= '0;
			sig_q <= '0; noi_q <= '0; dif_q <= '0; pow_q <= '0;
			mc_q <= '0; acc_q <= '0; mp_q <= '0; mcnt_q <= '0;
			rem_q <= '0; den_q <= '0; nlo_q <= '0; num_q <= '0; dq_q <= '0;
			dcnt_q <= '0; ov_q <= 1'b0;
			alpha_q <= gld_pkg::ALPHA_RESET;
			hcno_q <= gld_pkg::CNO_RESET;
			hrat_q <= '0;
			ovld_q <= 1'b0;
			olock_c_q <= 1'b0; olock_r_q <= 1'b0; ocno_q <= '0; orat_q <= '0;
		end else begin
			if (cfg.valid)
				alpha_q <= cfg.data;
			if (result.ready && st_q != ST_OUT)
				ovld_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (sample.valid) begin
						i_q <= sample.prompt_in_phase;
						q_q <= sample.prompt_quadrature;
						per_q <= sample.period_us;
						if (sample.period_us != last_q) begin
							last_q <= sample.period_us;
							cnt_q <= '0;
							sig_q <= '0; noi_q <= '0; dif_q <= '0; pow_q <= '0;
						end
						st_q <= ST_SQI;
					end
				end
				ST_SQI: begin
					ii_q <= 32'(32'(i_q) * 32'(i_q));
					st_q <= ST_SQQ;
				end
				ST_SQQ: begin
					qq_q <= 32'(32'(q_q) * 32'(q_q));
					st_q <= ST_PW;
				end
				ST_PW: begin
					pcur_q <= 32'(ii_q + qq_q);
					pdiff_q <= $signed(32'(ii_q - qq_q));
					rv_q <= {32'(ii_q + qq_q), 16'b0};
					rrem_q <= '0; rroot_q <= '0; rcnt_q <= '0; rsel_q <= 1'b0;
					st_q <= ST_RT;
				end
				ST_RT: begin
					if (rcnt_q == 5'd23) begin
						rcnt_q <= '0;
						if (!rsel_q) begin
							rc_q <= root_nxt;
							rsel_q <= 1'b1;
							rv_q <= {prev_q, 16'b0};
							rrem_q <= '0;
							rroot_q <= '0;
						end else begin
							rroot_q <= root_nxt;
							st_q <= ST_NZ;
						end
					end else begin
						rrem_q <= 26'(rrem_nxt);
						rroot_q <= root_nxt;
						rv_q <= {rv_q[45:0], 2'b00};
						rcnt_q <= rcnt_q + 5'd1;
					end
				end
				ST_NZ: begin
					nz_q <= drsq[47:0];
					warm_q <= (32'(cnt_q) < WARMUP_DUMPS);
					if (32'(cnt_q) < WARMUP_DUMPS)
						cnt_q <= cnt_q + CW'(1);
					fidx_q <= '0;
					st_q <= ST_FSET;
				end
				ST_FSET: begin
					neg_q <= dd[48];
					ret_q <= ST_FUPD;
					if (warm_q) begin
						rem_q <= '0;
						nlo_q <= {dm, 20'b0};
						den_q <= 65'(cnt_q);
						dq_q <= '0;
						ov_q <= 1'b0;
						dcnt_q <= 6'd47;
						st_q <= ST_DIV;
					end else begin
						mc_q <= 70'(dd);
						mp_q <= {4'b0, alpha_q};
						acc_q <= '0;
						mcnt_q <= 5'd19;
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mp_q[0])
						acc_q <= acc_q + mc_q;
					mc_q <= mc_q <<< 1;
					mp_q <= mp_q >> 1;
					mcnt_q <= mcnt_q - 5'd1;
					if (mcnt_q == '0)
						st_q <= ret_q;
				end
				ST_DIV: begin
					rem_q <= d_ge ? 65'(dt - {1'b0, den_q}) : dt[64:0];
					dq_q <= {dq_q[46:0], d_ge};
					nlo_q <= {nlo_q[66:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == '0)
						st_q <= ret_q;
				end
				ST_FUPD: begin
					case (fidx_q)
						2'd0: sig_q <= snew[47:0];
						2'd1: noi_q <= snew[47:0];
						2'd2: dif_q <= snew[47:0];
						default: pow_q <= snew[47:0];
					endcase
					fidx_q <= fidx_q + 2'd1;
					if (fidx_q == 2'd3)
						st_q <= warm_q ? ST_OUT : ST_CNO1;
					else
						st_q <= ST_FSET;
				end
				ST_CNO1: begin
					mc_q <= {22'b0, sig_q};
					mp_q <= gld_pkg::CNO_SCALE;
					acc_q <= '0;
					mcnt_q <= 5'd19;
					ret_q <= ST_CNO2;
					st_q <= ST_MUL;
				end
				ST_CNO2: begin
					num_q <= acc_q[67:0];
					mc_q <= {22'b0, noi_q};
					mp_q <= {3'b0, per_q};
					acc_q <= '0;
					mcnt_q <= 5'd19;
					ret_q <= ST_CNO3;
					st_q <= ST_MUL;
				end
				ST_CNO3: begin
					if (acc_q[64:0] == '0) begin
						hcno_q <= gld_pkg::CNO_MAX;
						st_q <= ST_RAT;
					end else begin
						rem_q <= {29'b0, num_q[67:32]};
						nlo_q <= {num_q[31:0], 36'b0};
						den_q <= acc_q[64:0];
						ov_q <= ({29'b0, num_q[67:32]} >= acc_q[64:0]);
						dq_q <= '0;
						dcnt_q <= 6'd31;
						ret_q <= ST_CNOF;
						st_q <= ST_DIV;
					end
				end
				ST_CNOF: begin
					hcno_q <= ov_q ? gld_pkg::CNO_MAX : dq_q[31:0];
					st_q <= ST_RAT;
				end
				ST_RAT: begin
					if (pow_q == '0) begin
						hrat_q <= '0;
						st_q <= ST_OUT;
					end else begin
						neg_q <= dif_q[47];
						rem_q <= {17'b0, rm[62:15]};
						nlo_q <= {rm[14:0], 53'b0};
						den_q <= {17'b0, pow_q};
						ov_q <= (rm[62:15] >= pow_q);
						dq_q <= '0;
						dcnt_q <= 6'd14;
						ret_q <= ST_RATF;
						st_q <= ST_DIV;
					end
				end
				ST_RATF: begin
					if (ov_q)
						hrat_q <= neg_q ? gld_pkg::RATIO_MIN : gld_pkg::RATIO_MAX;
					else
						hrat_q <= neg_q ? $signed(~{1'b0, dq_q[14:0]})
							: $signed({1'b0, dq_q[14:0]});
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ovld_q || result.ready) begin
						ovld_q <= 1'b1;
						ocno_q <= hcno_q;
						orat_q <= hrat_q;
						olock_c_q <= (hcno_q > gld_pkg::CNO_LOCK);
						olock_r_q <= (hrat_q > gld_pkg::RATIO_LOCK);
						prev_q <= pcur_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/gld_chk.sv
module gld_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic        cno_lock,
	input logic        carrier_lock,
	input logic [31:0] cno,
	input logic [15:0] ratio
);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("input accepted while busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(cno) && $stable(ratio))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> cno_lock == (cno > gld_pkg::CNO_LOCK))
		else $error("code lock mismatch");

	a_carr: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> carrier_lock == ($signed(ratio) > gld_pkg::RATIO_LOCK))
		else $error("carrier lock mismatch");

endmodule

bind gnss_lock_detector_with_warmup gld_chk u_gld_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_valid(sample.valid),
	.s_ready(sample.ready),
	.r_valid(result.valid),
	.r_ready(result.ready),
	.cno_lock(result.cno_lock),
	.carrier_lock(result.carrier_lock),
	.cno(result.cno_estimate),
	.ratio(result.carrier_ratio)
);
